FILE: sv/scan_code_to_ascii_decoder_macros.svh
// assertion macros for the scan code decoder checker
`ifndef SCAN_CODE_TO_ASCII_DECODER_MACROS_SVH
`define SCAN_CODE_TO_ASCII_DECODER_MACROS_SVH

// concurrent check sampled on the rising clock, switched off while reset is low
`define SCTAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check sampled on the rising clock, active during reset as well
`define SCTAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sctad_pkg.sv
// types, constants and lookup functions shared by the scan code decoder
`default_nettype none

package sctad_pkg;

    // scan code constants
    localparam logic [7:0] SC_PREFIX_SKIP2 = 8'hE1;
    localparam logic [7:0] SC_PREFIX_EXT   = 8'hE0;
    localparam logic [6:0] SC_LAST         = 7'h3A;
    localparam logic [6:0] SC_LSHIFT       = 7'h2A;
    localparam logic [6:0] SC_RSHIFT       = 7'h36;
    localparam logic [6:0] SC_CAPS         = 7'h3A;
    localparam logic [6:0] SC_UP           = 7'h48;
    localparam logic [6:0] SC_LEFT         = 7'h4B;
    localparam logic [6:0] SC_DOWN         = 7'h50;
    localparam logic [6:0] SC_RIGHT        = 7'h4D;
    localparam logic [6:0] CASE_OFFSET     = 7'd32;
    localparam logic [6:0] ASCII_LOWER_A   = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z   = 7'h7A;
    localparam logic [2:0] LED_CAPS        = 3'b100;

    // arrow directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // event kinds
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ARROW = 2'd1,
        KIND_LED   = 2'd2
    } t_kind;

    // prefix tracking, one-hot
    typedef enum logic [3:0] {
        PH_NONE  = 4'b0001,
        PH_EXT   = 4'b0010,
        PH_SKIP2 = 4'b0100,
        PH_SKIP1 = 4'b1000
    } t_phase;

    // decoder state
    typedef struct packed {
        t_phase phase;
        logic   shift_held;
        logic   caps_active;
    } t_state;

    // one decoded event
    typedef struct packed {
        t_kind      event_kind;
        logic [6:0] char_code;
        logic [1:0] arrow_dir;
        logic [2:0] led_bits;
        logic       shift_state;
    } t_result;

    // unshifted ascii per set-1 scan code, zero for unknown, shift and caps lock
    function automatic logic [6:0] ascii_lookup(input logic [5:0] code);
        logic [6:0] c;
        unique case (code)
            6'h01: c = 7'h1B;
            6'h02: c = 7'h31;
            6'h03: c = 7'h32;
            6'h04: c = 7'h33;
            6'h05: c = 7'h34;
            6'h06: c = 7'h35;
            6'h07: c = 7'h36;
            6'h08: c = 7'h37;
            6'h09: c = 7'h38;
            6'h0A: c = 7'h39;
            6'h0B: c = 7'h30;
            6'h0C: c = 7'h2D;
            6'h0D: c = 7'h3D;
            6'h0E: c = 7'h08;
            6'h0F: c = 7'h09;
            6'h10: c = 7'h71;
            6'h11: c = 7'h77;
            6'h12: c = 7'h65;
            6'h13: c = 7'h72;
            6'h14: c = 7'h74;
            6'h15: c = 7'h79;
            6'h16: c = 7'h75;
            6'h17: c = 7'h69;
            6'h18: c = 7'h6F;
            6'h19: c = 7'h70;
            6'h1A: c = 7'h5B;
            6'h1B: c = 7'h5D;
            6'h1C: c = 7'h0D;
            6'h1E: c = 7'h61;
            6'h1F: c = 7'h73;
            6'h20: c = 7'h64;
            6'h21: c = 7'h66;
            6'h22: c = 7'h67;
            6'h23: c = 7'h68;
            6'h24: c = 7'h6A;
            6'h25: c = 7'h6B;
            6'h26: c = 7'h6C;
            6'h27: c = 7'h3B;
            6'h28: c = 7'h27;
            6'h29: c = 7'h60;
            6'h2B: c = 7'h5C;
            6'h2C: c = 7'h7A;
            6'h2D: c = 7'h78;
            6'h2E: c = 7'h63;
            6'h2F: c = 7'h76;
            6'h30: c = 7'h62;
            6'h31: c = 7'h6E;
            6'h32: c = 7'h6D;
            6'h33: c = 7'h2C;
            6'h34: c = 7'h2E;
            6'h35: c = 7'h2F;
            6'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // us shifted form of digits and punctuation, others unchanged
    function automatic logic [6:0] shifted_symbol(input logic [6:0] c);
        logic [6:0] s;
        unique case (c)
            7'h30: s = 7'h29;
            7'h31: s = 7'h21;
            7'h32: s = 7'h40;
            7'h33: s = 7'h23;
            7'h34: s = 7'h24;
            7'h35: s = 7'h25;
            7'h36: s = 7'h5E;
            7'h37: s = 7'h26;
            7'h38: s = 7'h2A;
            7'h39: s = 7'h28;
            7'h60: s = 7'h7E;
            7'h2D: s = 7'h5F;
            7'h3D: s = 7'h2B;
            7'h5B: s = 7'h7B;
            7'h5D: s = 7'h7D;
            7'h5C: s = 7'h7C;
            7'h3B: s = 7'h3A;
            7'h27: s = 7'h22;
            7'h2C: s = 7'h3C;
            7'h2E: s = 7'h3E;
            7'h2F: s = 7'h3F;
            default: s = c;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sctad_decode.sv
// combinational decode of one scan byte against the current prefix and modifier state
`default_nettype none

module sctad_decode (
    input  wire logic [7:0]       i_scan_byte,
    input  wire sctad_pkg::t_state i_state,
    output sctad_pkg::t_state     o_next_state,
    output logic                  o_res_valid,
    output sctad_pkg::t_result    o_result
);
    import sctad_pkg::*;

    logic [6:0] w_code;
    logic       w_release;
    logic       w_is_shift;
    logic [6:0] w_ascii;
    logic       w_is_letter;

    assign w_code      = i_scan_byte[6:0];
    assign w_release   = i_scan_byte[7];
    assign w_is_shift  = (w_code == SC_LSHIFT) || (w_code == SC_RSHIFT);
    assign w_ascii     = (w_code <= SC_LAST) ? ascii_lookup(w_code[5:0]) : 7'h00;
    assign w_is_letter = (w_ascii >= ASCII_LOWER_A) && (w_ascii <= ASCII_LOWER_Z);

    // prefix phase, modifier flags and the event
    always_comb begin
        o_next_state = i_state;
        o_res_valid  = 1'b0;
        o_result     = '0;
        unique case (i_state.phase)
            PH_SKIP2: o_next_state.phase = PH_SKIP1;
            PH_SKIP1: o_next_state.phase = PH_NONE;
            PH_EXT: begin
                o_next_state.phase = PH_NONE;
                if (!w_release) begin
                    o_result.event_kind = KIND_ARROW;
                    unique case (w_code)
                        SC_UP: begin
                            o_res_valid        = 1'b1;
                            o_result.arrow_dir = DIR_UP;
                        end
                        SC_LEFT: begin
                            o_res_valid        = 1'b1;
                            o_result.arrow_dir = DIR_LEFT;
                        end
                        SC_DOWN: begin
                            o_res_valid        = 1'b1;
                            o_result.arrow_dir = DIR_DOWN;
                        end
                        SC_RIGHT: begin
                            o_res_valid        = 1'b1;
                            o_result.arrow_dir = DIR_RIGHT;
                        end
                        default: o_res_valid = 1'b0;
                    endcase
                end
            end
            default: begin
                o_next_state.phase = PH_NONE;
                priority if (i_scan_byte == SC_PREFIX_SKIP2) begin
                    o_next_state.phase = PH_SKIP2;
                end else if (i_scan_byte == SC_PREFIX_EXT) begin
                    o_next_state.phase = PH_EXT;
                end else if (w_release) begin
                    if (w_is_shift) begin
                        o_next_state.shift_held = 1'b0;
                    end
                end else if (w_is_shift) begin
                    o_next_state.shift_held = 1'b1;
                end else if (w_code == SC_CAPS) begin
                    o_next_state.caps_active = !i_state.caps_active;
                    o_res_valid              = 1'b1;
                    o_result.event_kind      = KIND_LED;
                    o_result.led_bits        = i_state.caps_active ? 3'b000 : LED_CAPS;
                end else if (w_ascii != 7'h00) begin
                    o_res_valid         = 1'b1;
                    o_result.event_kind = KIND_CHAR;
                    if (w_is_letter) begin
                        o_result.char_code = (i_state.shift_held || i_state.caps_active)
                                             ? (w_ascii - CASE_OFFSET) : w_ascii;
                    end else begin
                        o_result.char_code = i_state.shift_held ? shifted_symbol(w_ascii)
                                                                : w_ascii;
                    end
                end else begin
                    // unknown key, no event
                    o_res_valid = 1'b0;
                end
            end
        endcase
        o_result.shift_state = o_next_state.shift_held;
    end

endmodule

`default_nettype wire

FILE: sv/scan_code_to_ascii_decoder.sv
// top level: set-1 scan code to ascii decoder with input and result registers
//
// Input channel: i_valid / o_stall carry one scan byte on i_scan_byte. A request
// is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one event (kind, ascii, arrow
// direction, led bits, shift state). It is taken at an edge with o_valid high
// and i_stall low. Bytes that yield no event (prefixes, releases, shift keys,
// unknown keys) are absorbed silently.
// Path: an accepted byte enters the input register and is then decoded into the
// result register, which drives o_valid. Throughput: one byte per cycle while
// the receiver does not stall, set by the combinational table lookup and flag
// update between the two registers.
// Stall: a full result register waiting on i_stall holds its event; the input
// register still drains when the output is free, so o_stall only rises when both
// registers are occupied and the receiver stalls.
// Reset: synchronous, active low; clears the prefix phase, shift and caps lock
// flags and both valid flags.
`default_nettype none

module scan_code_to_ascii_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_scan_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_event_kind,
    output logic [6:0]      o_char_code,
    output logic [1:0]      o_arrow_dir,
    output logic [2:0]      o_led_bits,
    output logic            o_shift_state
);
    import sctad_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       w_dec_valid;
    logic       w_out_free;
    logic       w_adv;

    // handshake control
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_scan_byte;
        end
    end

    // decode
    sctad_decode u_decode (
        .i_scan_byte  (r_in_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_res_valid  (w_dec_valid),
        .o_result     (n_out)
    );

    // prefix and modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_NONE, shift_held: 1'b0, caps_active: 1'b0};
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && w_dec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_dec_valid) begin
            r_out <= n_out;
        end
    end

    // outputs
    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_out.event_kind;
    assign o_char_code   = r_out.char_code;
    assign o_arrow_dir   = r_out.arrow_dir;
    assign o_led_bits    = r_out.led_bits;
    assign o_shift_state = r_out.shift_state;

endmodule

`default_nettype wire

FILE: sv/sctad_checker.sv
// port-level checker for the scan code decoder and its bind
`default_nettype none

`include "scan_code_to_ascii_decoder_macros.svh"

module sctad_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [7:0] i_scan_byte,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_event_kind,
    input wire logic [6:0] o_char_code,
    input wire logic [1:0] o_arrow_dir,
    input wire logic [2:0] o_led_bits,
    input wire logic       o_shift_state
);
    import sctad_pkg::*;

    // a stalled request holds
    `SCTAD_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_scan_byte), "stalled request changed")

    // a stalled event holds
    `SCTAD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable({o_event_kind, o_char_code, o_arrow_dir, o_led_bits, o_shift_state}), "stalled event changed")

    // input back-pressure only when an event is waiting
    `SCTAD_ASSERT(a_stall_needs_out, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled without a waiting event")

    // unused fields of an event are zero and the kind is legal
    `SCTAD_ASSERT(a_fields_clean, i_clk, i_rst_n, o_valid |-> (o_event_kind == KIND_CHAR && o_arrow_dir == 2'd0 && o_led_bits == 3'd0) || (o_event_kind == KIND_ARROW && o_char_code == 7'd0 && o_led_bits == 3'd0) || (o_event_kind == KIND_LED && o_char_code == 7'd0 && o_arrow_dir == 2'd0), "event fields inconsistent with kind")

    // nothing valid straight after reset
    `SCTAD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && !o_stall, "channel busy after reset")

endmodule

bind scan_code_to_ascii_decoder sctad_checker u_sctad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_scan_byte   (i_scan_byte),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_event_kind  (o_event_kind),
    .o_char_code   (o_char_code),
    .o_arrow_dir   (o_arrow_dir),
    .o_led_bits    (o_led_bits),
    .o_shift_state (o_shift_state)
);

`default_nettype wire

FILE: verif/tb_scan_code_to_ascii_decoder.sv
// testbench for the set-1 scan code to ascii decoder: random keyboard traffic, scoreboard
`timescale 1ns / 100ps

module tb_scan_code_to_ascii_decoder;

    import sctad_pkg::*;

    localparam int DIRECTED_COUNT = 32;
    localparam int RANDOM_COUNT   = 500;
    localparam int CALM_TAIL      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 100000;

    // prefix tracking of the predictor
    typedef enum logic [1:0] {
        PFX_IDLE,
        PFX_EXTENDED,
        PFX_DROP_TWO,
        PFX_DROP_ONE
    } t_prefix;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_scan_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_event_kind;
    logic [6:0] o_char_code;
    logic [1:0] o_arrow_dir;
    logic [2:0] o_led_bits;
    logic       o_shift_state;

    logic [7:0] scan_bytes_pending [$];
    t_result    events_due [$];

    // predictor state
    t_prefix    pfx_phase  = PFX_IDLE;
    logic       shift_down = 1'b0;
    logic       caps_on    = 1'b0;

    logic       req_taken  = 1'b0;
    int         gap_left   = 0;
    int         stall_left = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    // unshifted ascii per scan code, zero where no character exists
    byte key_ascii [0:58] = '{
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
        8'h08, 8'h09,
        "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0D, 8'h00,
        "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60, 8'h00, "\\",
        "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00, 8'h00, 8'h00,
        " ", 8'h00
    };

    // us keyboard symbol pairs, plain and shifted
    byte sym_plain [0:20] = '{
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
        8'h60, "-", "=", "[", "]", "\\", ";", "'", ",", ".", "/"
    };
    byte sym_shift [0:20] = '{
        ")", "!", "@", "#", "$", "%", "^", "&", "*", "(",
        "~", "_", "+", "{", "}", "|", ":", "\"", "<", ">", "?"
    };

    logic [6:0] arrow_codes [0:3] = '{SC_UP, SC_LEFT, SC_DOWN, SC_RIGHT};

    scan_code_to_ascii_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_scan_byte   (i_scan_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_char_code   (o_char_code),
        .o_arrow_dir   (o_arrow_dir),
        .o_led_bits    (o_led_bits),
        .o_shift_state (o_shift_state)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decode one scan byte, updating the predicted flags; returns 1 when an event is due
    function automatic bit decode_scan_byte(input logic [7:0] b, output t_result evt);
        logic [6:0] code;
        logic       rel;
        logic [6:0] ch;
        code = b[6:0];
        rel  = b[7];
        evt  = '0;
        // bytes after a pending prefix: dropped, or decoded as arrows after the extended prefix
        case (pfx_phase)
            PFX_DROP_TWO: begin
                pfx_phase = PFX_DROP_ONE;
                return 1'b0;
            end
            PFX_DROP_ONE: begin
                pfx_phase = PFX_IDLE;
                return 1'b0;
            end
            PFX_EXTENDED: begin
                pfx_phase = PFX_IDLE;
                if (rel)
                    return 1'b0;
                evt.event_kind  = KIND_ARROW;
                evt.shift_state = shift_down;
                case (code)
                    SC_UP:    evt.arrow_dir = DIR_UP;
                    SC_LEFT:  evt.arrow_dir = DIR_LEFT;
                    SC_DOWN:  evt.arrow_dir = DIR_DOWN;
                    SC_RIGHT: evt.arrow_dir = DIR_RIGHT;
                    default:  return 1'b0;
                endcase
                return 1'b1;
            end
            default: ;
        endcase
        // new prefixes
        if (b == SC_PREFIX_SKIP2) begin
            pfx_phase = PFX_DROP_TWO;
            return 1'b0;
        end
        if (b == SC_PREFIX_EXT) begin
            pfx_phase = PFX_EXTENDED;
            return 1'b0;
        end
        // shift tracking
        if (rel) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT)
                shift_down = 1'b0;
            return 1'b0;
        end
        if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_down = 1'b1;
            return 1'b0;
        end
        // caps lock toggles and reports the led byte
        if (code == SC_CAPS) begin
            caps_on         = ~caps_on;
            evt.event_kind  = KIND_LED;
            evt.led_bits    = caps_on ? LED_CAPS : 3'b000;
            evt.shift_state = shift_down;
            return 1'b1;
        end
        if (code > SC_LAST)
            return 1'b0;
        ch = key_ascii[code][6:0];
        if (ch == 7'h00)
            return 1'b0;
        // letter case and shifted symbols
        if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
            if (shift_down || caps_on)
                ch = ch - CASE_OFFSET;
        end else if (shift_down) begin
            for (int k = 0; k < 21; k++)
                if (sym_plain[k][6:0] == ch) begin
                    ch = sym_shift[k][6:0];
                    break;
                end
        end
        evt.event_kind  = KIND_CHAR;
        evt.char_code   = ch;
        evt.shift_state = shift_down;
        return 1'b1;
    endfunction

    // driver: requests and receiver stalls change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // input side
            if (!i_valid || req_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (scan_bytes_pending.size() > CALM_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 8);
                    i_valid  <= 1'b0;
                end else if (scan_bytes_pending.size() > 0) begin
                    i_valid     <= 1'b1;
                    i_scan_byte <= scan_bytes_pending[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
            // output side
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (scan_bytes_pending.size() > CALM_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(0, 8);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor: check events, then predict from the request taken at this edge
    always @(posedge i_clk) begin
        t_result evt;
        t_result due;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (events_due.size() == 0) begin
                    $error("unexpected event kind %0d char %0h dir %0d led %0d shift %0d",
                           o_event_kind, o_char_code, o_arrow_dir, o_led_bits,
                           o_shift_state);
                    error_count++;
                end else begin
                    due = events_due.pop_front();
                    if (o_event_kind !== due.event_kind) begin
                        $error("event_kind expected %0d got %0d", due.event_kind,
                               o_event_kind);
                        error_count++;
                    end
                    if (o_char_code !== due.char_code) begin
                        $error("char_code expected %0h got %0h", due.char_code,
                               o_char_code);
                        error_count++;
                    end
                    if (o_arrow_dir !== due.arrow_dir) begin
                        $error("arrow_dir expected %0d got %0d", due.arrow_dir,
                               o_arrow_dir);
                        error_count++;
                    end
                    if (o_led_bits !== due.led_bits) begin
                        $error("led_bits expected %0d got %0d", due.led_bits,
                               o_led_bits);
                        error_count++;
                    end
                    if (o_shift_state !== due.shift_state) begin
                        $error("shift_state expected %0d got %0d", due.shift_state,
                               o_shift_state);
                        error_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                void'(scan_bytes_pending.pop_front());
                if (decode_scan_byte(i_scan_byte, evt))
                    events_due.push_back(evt);
            end
            req_taken <= i_valid && !o_stall;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int         pick;
        logic [6:0] code;
        // directed: discard prefix, unknown keys, shift and caps rules, arrows
        scan_bytes_pending = '{
            SC_PREFIX_SKIP2, SC_PREFIX_EXT, 8'hC8,
            8'h00, 8'h37, 8'h3B, 8'h7F,
            8'h2A, 8'h02, 8'h10, 8'h29, 8'h39,
            8'hAA, 8'h3A, 8'h1E, 8'h02,
            SC_PREFIX_EXT, 8'h48, SC_PREFIX_EXT, 8'hCB, SC_PREFIX_EXT, 8'h4B,
            SC_PREFIX_EXT, 8'h50, SC_PREFIX_EXT, 8'h4D,
            SC_PREFIX_EXT, SC_PREFIX_SKIP2,
            8'h3A, 8'hFF, 8'h80, 8'h1C
        };
        // random traffic, mostly well-formed key sequences
        while (scan_bytes_pending.size() < DIRECTED_COUNT + RANDOM_COUNT) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: begin
                    code = 7'($urandom_range(1, 58));
                    scan_bytes_pending.push_back({1'b0, code});
                    if ($urandom_range(0, 1))
                        scan_bytes_pending.push_back({1'b1, code});
                end
                4: scan_bytes_pending.push_back(
                       {1'b0, $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT});
                5: scan_bytes_pending.push_back(
                       {1'b1, $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT});
                6: begin
                    scan_bytes_pending.push_back(SC_PREFIX_EXT);
                    if ($urandom_range(0, 3) == 0)
                        scan_bytes_pending.push_back(8'($urandom_range(0, 255)));
                    else
                        scan_bytes_pending.push_back(
                            {$urandom_range(0, 4) == 0, arrow_codes[$urandom_range(0, 3)]});
                end
                7: begin
                    scan_bytes_pending.push_back({1'b0, SC_CAPS});
                    scan_bytes_pending.push_back({1'b1, SC_CAPS});
                end
                8: begin
                    scan_bytes_pending.push_back(SC_PREFIX_SKIP2);
                    scan_bytes_pending.push_back(8'($urandom_range(0, 255)));
                    scan_bytes_pending.push_back(8'($urandom_range(0, 255)));
                end
                default: scan_bytes_pending.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        // hold reset at the start, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait for every request and event, then let the pipeline settle
        while (scan_bytes_pending.size() != 0 || events_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
